// ===== hdl/csi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_pkg
// Shared constants and the arctangent table for the circle/segment hit test.
// ----------------------------------------------------------------------------
package csi_pkg;

  localparam int ANGLE_W    = 16;
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 8;
  localparam int U_FRAC     = 30;
  localparam int U_W        = 34;
  localparam int Z_W        = 34;

  localparam logic signed [U_W-1:0] CORDIC_K = 34'sd652032874;

  // arctan(2^-i) in units of 2^32 per turn
  function automatic logic signed [Z_W-1:0] atan_turn(input int unsigned i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679838;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/csi_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_cordic
// Pipelined rotation CORDIC: binary angle to Q1.30 unit direction, one
// iteration per stage, with a side payload carried alongside.
// ----------------------------------------------------------------------------
module csi_cordic #(
  parameter int STAGES = 16,
  parameter int SIDE_W = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [csi_pkg::ANGLE_W-1:0]         in_angle,
  input  logic [SIDE_W-1:0]                   in_side,
  output logic                                out_valid,
  output logic signed [csi_pkg::U_W-1:0]      ux,
  output logic signed [csi_pkg::U_W-1:0]      uy,
  output logic [SIDE_W-1:0]                   out_side
);

  logic signed [csi_pkg::U_W-1:0] xs [0:STAGES];
  logic signed [csi_pkg::U_W-1:0] ys [0:STAGES];
  logic signed [csi_pkg::Z_W-1:0] zs [0:STAGES];
  logic                           flip [0:STAGES];
  logic                           vld [0:STAGES];
  logic [SIDE_W-1:0]              side [0:STAGES];

  logic                        fold;
  logic [csi_pkg::ANGLE_W-1:0] ang_f;

  // fold into [-90, 90) degrees; negate the result later
  assign fold  = in_angle[csi_pkg::ANGLE_W-1] ^ in_angle[csi_pkg::ANGLE_W-2];
  assign ang_f = {in_angle[csi_pkg::ANGLE_W-1] ^ fold, in_angle[csi_pkg::ANGLE_W-2:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      xs[0]   <= csi_pkg::CORDIC_K;
      ys[0]   <= '0;
      zs[0]   <= {{(csi_pkg::Z_W-32){ang_f[csi_pkg::ANGLE_W-1]}}, ang_f, 16'b0};
      flip[0] <= fold;
      side[0] <= in_side;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [csi_pkg::U_W-1:0] dx, dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        if (!zs[i][csi_pkg::Z_W-1]) begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - csi_pkg::atan_turn(i);
        end else begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + csi_pkg::atan_turn(i);
        end
        flip[i+1] <= flip[i];
        side[i+1] <= side[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[STAGES];
    end
    if (en) begin
      ux       <= flip[STAGES] ? -xs[STAGES] : xs[STAGES];
      uy       <= flip[STAGES] ? -ys[STAGES] : ys[STAGES];
      out_side <= side[STAGES];
    end
  end

endmodule

// ===== hdl/csi_geom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_geom
// Five-stage distance test: products, sums, partial squares and compares,
// square sums, decision.
// ----------------------------------------------------------------------------
module csi_geom #(
  parameter int CW = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic signed [csi_pkg::U_W-1:0]  ux,
  input  logic signed [csi_pkg::U_W-1:0]  uy,
  input  logic signed [CW:0]              dxs,
  input  logic signed [CW:0]              dys,
  input  logic [CW+7:0]                   rad,
  input  logic [CW+7:0]                   len,
  output logic                            out_valid,
  output logic                            hit
);

  localparam int SW  = CW + 8;                 // scaled radius / length
  localparam int SL  = SW / 2;                 // low half of a scaled value
  localparam int SH  = SW - SL;                // high half of a scaled value
  localparam int PW  = csi_pkg::U_W + CW + 1;  // u times offset
  localparam int LW  = csi_pkg::U_W + SW + 1;  // u times length
  localparam int EW  = LW + 1;                 // far endpoint, Q.46
  localparam int EQW = EW - csi_pkg::U_FRAC;   // far endpoint, Q16.16
  localparam int EL  = EQW / 2;                // low half of an endpoint offset
  localparam int EH  = EQW - EL;               // high half, signed
  localparam int CMW = CW + 48;                // compare width for Q.46
  localparam int QW  = 2 * EQW + 1;            // squared distances

  // stage 1
  logic              v1, lz1;
  logic signed [PW-1:0] pxdx, pydy, pxdy, pydx;
  logic signed [csi_pkg::U_W+SH:0] pxlh, pylh;
  logic signed [csi_pkg::U_W+SL:0] pxll, pyll;
  logic signed [CW:0]   dx1, dy1;
  logic [2*SH-1:0]      rhh1;
  logic [SH+SL-1:0]     rhl1;
  logic [2*SL-1:0]      rll1;
  logic [2*CW+1:0]      dx2, dy2;
  logic [SW-1:0]        rad1, len1;

  // stage 2
  logic              v2, lz2;
  logic signed [PW:0]   cross2, t2;
  logic signed [EQW-1:0] ex2, ey2;
  logic [2*CW+2:0]      pd2;
  logic [2*SW-1:0]      r2_2;
  logic [SW-1:0]        rad2, len2;

  // stage 3
  logic              v3, lz3, far3, tneg3, tgt3, pok3;
  logic signed [2*EH-1:0] exhh3, eyhh3;
  logic signed [EH+EL:0]  exhl3, eyhl3;
  logic [2*EL-1:0]        exll3, eyll3;
  logic [2*SW-1:0]      r2_3;

  // stage 4
  logic              v4, lz4, far4, tneg4, tgt4, pok4;
  logic [2*EQW-1:0]     exq4, eyq4;
  logic [2*SW-1:0]      r2_4;

  logic signed [EW-1:0] exf, eyf;
  logic signed [PW:0]   cabs;
  logic signed [EH-1:0] exh, eyh;
  logic [EL-1:0]        exl, eyl;

  always_comb begin
    // u times length arrives as two partial products
    exf  = (EW'(dx1) <<< csi_pkg::U_FRAC) - (EW'(pxlh) <<< SL) - EW'(pxll);
    eyf  = (EW'(dy1) <<< csi_pkg::U_FRAC) - (EW'(pylh) <<< SL) - EW'(pyll);
    cabs = cross2[PW] ? -cross2 : cross2;
    exh  = ex2[EQW-1 -: EH];
    eyh  = ey2[EQW-1 -: EH];
    exl  = ex2[EL-1:0];
    eyl  = ey2[EL-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
    if (en) begin
      // multiply
      pxdx <= ux * dxs;
      pydy <= uy * dys;
      pxdy <= ux * dys;
      pydx <= uy * dxs;
      pxlh <= ux * $signed({1'b0, len[SW-1 -: SH]});
      pylh <= uy * $signed({1'b0, len[SW-1 -: SH]});
      pxll <= ux * $signed({1'b0, len[SL-1:0]});
      pyll <= uy * $signed({1'b0, len[SL-1:0]});
      rhh1 <= rad[SW-1 -: SH] * rad[SW-1 -: SH];
      rhl1 <= rad[SW-1 -: SH] * rad[SL-1:0];
      rll1 <= rad[SL-1:0] * rad[SL-1:0];
      dx2  <= $unsigned((2*CW+2)'(dxs) * (2*CW+2)'(dxs));
      dy2  <= $unsigned((2*CW+2)'(dys) * (2*CW+2)'(dys));
      dx1  <= dxs;
      dy1  <= dys;
      rad1 <= rad;
      len1 <= len;
      lz1  <= (len == '0);
      // accumulate
      cross2 <= (PW+1)'(pxdy) - (PW+1)'(pydx);
      t2     <= (PW+1)'(pxdx) + (PW+1)'(pydy);
      ex2    <= EQW'(exf >>> csi_pkg::U_FRAC);
      ey2    <= EQW'(eyf >>> csi_pkg::U_FRAC);
      pd2    <= (2*CW+3)'(dx2) + (2*CW+3)'(dy2);
      r2_2   <= ((2*SW)'(rhh1) << (2*SL)) + ((2*SW)'(rhl1) << (SL+1)) + (2*SW)'(rll1);
      rad2   <= rad1;
      len2   <= len1;
      lz2    <= lz1;
      // partial squares and compare
      exhh3 <= exh * exh;
      eyhh3 <= eyh * eyh;
      exhl3 <= exh * $signed({1'b0, exl});
      eyhl3 <= eyh * $signed({1'b0, eyl});
      exll3 <= exl * exl;
      eyll3 <= eyl * eyl;
      far3  <= CMW'($unsigned(cabs)) > (CMW'(rad2) << csi_pkg::U_FRAC);
      tneg3 <= t2[PW];
      tgt3  <= CMW'($unsigned(t2)) > (CMW'(len2) << csi_pkg::U_FRAC);
      pok3  <= QW'(pd2) <= QW'(r2_2);
      r2_3  <= r2_2;
      lz3   <= lz2;
      // sum the partial squares
      exq4  <= (2*EQW)'((QW'(exhh3) <<< (2*EL)) + (QW'(exhl3) <<< (EL+1)) + QW'(exll3));
      eyq4  <= (2*EQW)'((QW'(eyhh3) <<< (2*EL)) + (QW'(eyhl3) <<< (EL+1)) + QW'(eyll3));
      far4  <= far3;
      tneg4 <= tneg3;
      tgt4  <= tgt3;
      pok4  <= pok3;
      r2_4  <= r2_3;
      lz4   <= lz3;
      // decide
      priority if (lz4) begin
        hit <= pok4;
      end else if (far4) begin
        hit <= 1'b0;
      end else if (tneg4) begin
        hit <= pok4;
      end else if (tgt4) begin
        hit <= (QW'(exq4) + QW'(eyq4)) <= QW'(r2_4);
      end else begin
        hit <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/circle_segment_intersect_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_segment_intersect_unit
// Path: input and scale registers, CORDIC, geometry test, result register.
// Throughput: one item per cycle; the CORDIC chain, one iteration per stage,
// sets the depth. A stall on the result side holds every stage in place.
// Reset clears all valid bits; no item is in flight after reset.
// ----------------------------------------------------------------------------
module circle_segment_intersect_unit #(
  parameter int COORD_WIDTH   = 32,
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // circle_x, circle_y, circle_rad, circle_scale, seg_start_x, seg_start_y,
  // seg_angle, seg_length, seg_scale, zero pad
  input  logic [((6*COORD_WIDTH+48+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // hit, zero pad
  output logic [7:0] m_axis_tdata
);

  localparam int CW     = COORD_WIDTH;
  localparam int SW     = CW + 8;
  localparam int SIDE_W = 2 * (CW + 1) + 2 * SW;

  logic en;
  logic va, vb;
  logic signed [CW-1:0] cx, cy, sx, sy;
  logic [CW-1:0] crad, slen;
  logic [csi_pkg::SCALE_W-1:0] cscl, sscl;
  logic [csi_pkg::ANGLE_W-1:0] ang_a, ang_b;
  logic signed [CW:0] dxs_b, dys_b, dxs_c, dys_c;
  logic [SW-1:0] rad_b, len_b, rad_c, len_c;
  logic [CW+csi_pkg::SCALE_W-1:0] rprod, lprod;
  logic cv, gv, ghit, hit_q;
  logic signed [csi_pkg::U_W-1:0] ux, uy;

  // every stage advances together unless the result register is stalled
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !rst;

  assign rprod = crad * cscl;
  assign lprod = slen * sscl;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      va <= s_axis_tvalid;
      vb <= va;
      m_axis_tvalid <= gv;
    end
    if (en) begin
      cx    <= s_axis_tdata[0 +: CW];
      cy    <= s_axis_tdata[CW +: CW];
      crad  <= s_axis_tdata[2*CW +: CW];
      cscl  <= s_axis_tdata[3*CW +: csi_pkg::SCALE_W];
      sx    <= s_axis_tdata[3*CW+16 +: CW];
      sy    <= s_axis_tdata[4*CW+16 +: CW];
      ang_a <= s_axis_tdata[5*CW+16 +: csi_pkg::ANGLE_W];
      slen  <= s_axis_tdata[5*CW+32 +: CW];
      sscl  <= s_axis_tdata[6*CW+32 +: csi_pkg::SCALE_W];
      rad_b <= rprod[csi_pkg::SCALE_FRAC +: SW];
      len_b <= lprod[csi_pkg::SCALE_FRAC +: SW];
      dxs_b <= (CW+1)'(cx) - (CW+1)'(sx);
      dys_b <= (CW+1)'(cy) - (CW+1)'(sy);
      ang_b <= ang_a;
      hit_q <= ghit;
    end
  end

  csi_cordic #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (SIDE_W)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vb),
    .in_angle  (ang_b),
    .in_side   ({dxs_b, dys_b, rad_b, len_b}),
    .out_valid (cv),
    .ux        (ux),
    .uy        (uy),
    .out_side  ({dxs_c, dys_c, rad_c, len_c})
  );

  csi_geom #(
    .CW (CW)
  ) u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cv),
    .ux        (ux),
    .uy        (uy),
    .dxs       (dxs_c),
    .dys       (dys_c),
    .rad       (rad_c),
    .len       (len_c),
    .out_valid (gv),
    .hit       (ghit)
  );

  assign m_axis_tdata = {7'b0, hit_q};

endmodule

// ===== verif/circle_segment_intersect_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_segment_intersect_unit_tb
// Streams circle/segment pairs through the hit-test unit and compares each
// hit bit with a cycle-free model of the CORDIC direction and the distance
// tests. Directed rows come first, then random geometry under random idling and stalls.
// ----------------------------------------------------------------------------
module circle_segment_intersect_unit_tb;

  localparam int CW = 32;
  localparam int STAGES = 16;
  localparam int DW = ((6*CW+48+7)/8)*8;
  localparam int LAT = STAGES + 10;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic signed [CW-1:0] cx, cy;
    logic [CW-1:0] rad;
    logic [15:0] cscale;
    logic signed [CW-1:0] sx, sy;
    logic [15:0] ang;
    logic [CW-1:0] len;
    logic [15:0] sscale;
  } geom_t;

  // directed row: item, plus a typed expectation where one is obvious
  typedef struct {
    geom_t g;
    bit known;
    bit hit;
  } row_t;

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, m_axis_tready = 0;
  logic [DW-1:0] s_axis_tdata = '0;
  logic s_axis_tready, m_axis_tvalid;
  logic [7:0] m_axis_tdata;

  bit hit_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle = 0, recv_stall = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  circle_segment_intersect_unit #(.COORD_WIDTH(CW), .CORDIC_STAGES(STAGES)) u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  function automatic logic [DW-1:0] pack_geom(geom_t g);
    logic [DW-1:0] d;
    d = '0;
    d[6*CW+48-1:0] = {g.sscale, g.len, g.ang, g.sy, g.sx, g.cscale, g.rad, g.cy, g.cx};
    return d;
  endfunction

  function automatic logic [127:0] mag_sq(logic signed [127:0] a, logic signed [127:0] b);
    logic [127:0] ma, mb;
    ma = a[127] ? -a : a;
    mb = b[127] ? -b : b;
    return ma * ma + mb * mb;
  endfunction

  // unit direction in Q1.30 from a binary angle
  function automatic void unit_dir(input logic [15:0] ang, output logic signed [63:0] ux,
                                   output logic signed [63:0] uy);
    logic [15:0] a;
    logic flip;
    logic signed [63:0] x, y, z, dx, dy;
    a = ang;
    flip = a[15] ^ a[14];
    if (flip) a = a - 16'h8000;
    z = 64'(signed'(a)) * 65536;
    x = 64'(csi_pkg::CORDIC_K);
    y = 0;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - 64'(csi_pkg::atan_turn(i));
      end else begin
        x = x + dx; y = y - dy; z = z + 64'(csi_pkg::atan_turn(i));
      end
    end
    ux = flip ? -x : x;
    uy = flip ? -y : y;
  endfunction

  function automatic bit predict_hit(geom_t g);
    logic [127:0] r, l, r2;
    logic signed [127:0] dx, dy, ux, uy, crs, t, ex, ey, acrs;
    logic signed [63:0] ux64, uy64;
    r = (128'(g.rad) * 128'(g.cscale)) >> 8;
    l = (128'(g.len) * 128'(g.sscale)) >> 8;
    dx = 128'(signed'(g.cx)) - 128'(signed'(g.sx));
    dy = 128'(signed'(g.cy)) - 128'(signed'(g.sy));
    r2 = r * r;
    if (l == 0) return mag_sq(dx, dy) <= r2;
    unit_dir(g.ang, ux64, uy64);
    ux = 128'(ux64);
    uy = 128'(uy64);
    crs = ux * dy - uy * dx;
    t = ux * dx + uy * dy;
    acrs = crs[127] ? -crs : crs;
    if (acrs > (r << 30)) return 0;
    if (t < 0) return mag_sq(dx, dy) <= r2;
    if (t > signed'(l << 30)) begin
      ex = ((dx <<< 30) - ux * signed'(l)) >>> 30;
      ey = ((dy <<< 30) - uy * signed'(l)) >>> 30;
      return mag_sq(ex, ey) <= r2;
    end
    return 1;
  endfunction

  function automatic geom_t rand_geom();
    geom_t g;
    int sh;
    g.ang = 16'($urandom);
    g.cscale = 16'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 1024));
    g.sscale = 16'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 1024));
    if ($urandom_range(0, 9) == 0) begin
      // wide-open noise over every bit
      g.cx = $urandom; g.cy = $urandom; g.sx = $urandom; g.sy = $urandom;
      g.rad = $urandom; g.len = $urandom;
    end else begin
      // nearby geometry so that hits and misses both occur often
      sh = $urandom_range(12, 26);
      g.sx = $signed($urandom) >>> (31 - sh);
      g.sy = $signed($urandom) >>> (31 - sh);
      g.cx = g.sx + ($signed($urandom) >>> (32 - sh));
      g.cy = g.sy + ($signed($urandom) >>> (32 - sh));
      g.rad = $urandom >> (33 - sh);
      g.len = $urandom_range(0, 7) == 0 ? 0 : $urandom >> (32 - sh);
    end
    return g;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(geom_t g);
    while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tdata <= pack_geom(g);
    s_axis_tvalid <= 1;
    do @(posedge clk); while (!s_axis_tready);
    hit_q.push_back(predict_hit(g));
    @(negedge clk);
  endtask

  // receiver: random stall, check on every result transfer
  always @(negedge clk)
    m_axis_tready <= !rst && !(recv_stall > 0 && $urandom_range(0, 99) < recv_stall);

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (hit_q.size() == 0) begin
        $error("hit: unexpected result %0d", m_axis_tdata[0]);
        errors++;
      end else begin
        bit want;
        want = hit_q.pop_front();
        if (m_axis_tdata[0] !== want) begin
          $error("hit: expected %0d actual %0d", want, m_axis_tdata[0]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("circle_segment_intersect_unit_tb: FAIL");
      $finish;
    end
  end

  function automatic geom_t mk(int cx, int cy, int unsigned rad, int cs, int sx, int sy,
                               int ang, int unsigned len, int ss);
    geom_t g;
    g.cx = cx; g.cy = cy; g.rad = rad; g.cscale = 16'(cs);
    g.sx = sx; g.sy = sy; g.ang = 16'(ang); g.len = len; g.sscale = 16'(ss);
    return g;
  endfunction

  row_t rows[$];

  initial begin
    int n;
    // point test at the center, zero radius: distance exactly zero counts
    rows.push_back('{mk(0, 0, 0, 256, 0, 0, 0, 0, 256), 1, 1});
    rows.push_back('{mk(65536, 0, 0, 256, 0, 0, 0, 0, 256), 1, 0});
    // point just touching: |D| == R
    rows.push_back('{mk(65536, 0, 65536, 256, 0, 0, 0, 65536, 0), 1, 1});
    rows.push_back('{mk(65537, 0, 65536, 256, 0, 0, 0, 0, 256), 1, 0});
    // segment along +x through the circle
    rows.push_back('{mk(5 << 16, 0, 1 << 16, 256, 0, 0, 0, 10 << 16, 256), 1, 1});
    // circle far behind the start, far beyond the end
    rows.push_back('{mk(-100 << 16, 0, 1 << 16, 256, 0, 0, 0, 10 << 16, 256), 1, 0});
    rows.push_back('{mk(100 << 16, 0, 1 << 16, 256, 0, 0, 0, 10 << 16, 256), 1, 0});
    // off to the side
    rows.push_back('{mk(5 << 16, 50 << 16, 1 << 16, 256, 0, 0, 0, 10 << 16, 256), 1, 0});
    // quadrants, folded angles, end overlap, zero scales
    for (int a = 0; a < 65536; a += 16384)
      rows.push_back('{mk(0, 3 << 16, 1 << 16, 256, 0, 0, a, 4 << 16, 256), 0, 0});
    rows.push_back('{mk(0, 0, 2 << 16, 256, 0, 0, 16'hBFFF, 5 << 16, 256), 0, 0});
    rows.push_back('{mk(0, 0, 2 << 16, 256, 0, 0, 16'h4000, 5 << 16, 256), 0, 0});
    rows.push_back('{mk(11 << 16, 0, 2 << 16, 256, 0, 0, 0, 10 << 16, 256), 0, 0});
    rows.push_back('{mk(-(1 << 16), 0, 2 << 16, 256, 0, 0, 0, 10 << 16, 256), 0, 0});
    rows.push_back('{mk(0, 0, 1 << 16, 0, 0, 0, 0, 1 << 16, 0), 1, 1});
    // field extremes
    rows.push_back('{mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 16'hFFFF,
                        32'h80000000, 32'h80000000, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF), 0, 0});
    rows.push_back('{mk(32'h80000000, 32'h80000000, 0, 0,
                        32'h7FFFFFFF, 32'h7FFFFFFF, 16'h8000, 32'hFFFFFFFF, 16'hFFFF), 0, 0});
    rows.push_back('{mk(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 16'hFFFF,
                        32'h80000000, 32'h7FFFFFFF, 16'h2000, 0, 0), 1, 1});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    foreach (rows[i]) begin
      if (rows[i].known && predict_hit(rows[i].g) != rows[i].hit) begin
        $error("hit: row %0d expected %0d actual %0d", i, rows[i].hit,
               predict_hit(rows[i].g));
        errors++;
      end
      send_item(rows[i].g);
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1) ? 51 : (ph == 3) ? 35 : 0;
      recv_stall = (ph == 2) ? 51 : (ph == 3) ? 35 : 0;
      n = 0;
      while (n < 400) begin
        send_item(rand_geom());
        n++;
        // hold off until the pipe drains
        if (ph == 2 && n == 200) begin
          s_axis_tvalid <= 0;
          wait (hit_q.size() == 0);
          @(negedge clk);
        end
      end
    end
    s_axis_tvalid <= 0;

    wait (hit_q.size() == 0);
    repeat (LAT + 10) @(posedge clk);
    if (errors == 0)
      $display("circle_segment_intersect_unit_tb: PASS");
    else
      $display("circle_segment_intersect_unit_tb: FAIL");
    $finish;
  end

endmodule
